FILE: rtl/cpve_pkg.sv
// ----------------------------------------------------------------------------
// cpve_pkg
// Shared constants and types for the convex polygon vertex editor.
// ----------------------------------------------------------------------------
package cpve_pkg;

  localparam int unsigned MaxVert = 64;
  localparam int unsigned AddrW   = $clog2(MaxVert);
  localparam int unsigned CntW    = $clog2(MaxVert + 3);

  localparam logic [2:0] MODE_CLEAR  = 3'd0;
  localparam logic [2:0] MODE_APPEND = 3'd1;
  localparam logic [2:0] MODE_TEST   = 3'd2;
  localparam logic [2:0] MODE_INSERT = 3'd3;
  localparam logic [2:0] MODE_MOVE   = 3'd4;
  localparam logic [2:0] MODE_REMOVE = 3'd5;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } vtx_t;

  // three consecutive candidate vertices: v0 -> v1 -> v2
  typedef struct packed {
    vtx_t v0;
    vtx_t v1;
    vtx_t v2;
  } win_t;

endpackage

FILE: rtl/cpve_cross.sv
// ----------------------------------------------------------------------------
// cpve_cross
// Shared multiplier for the edge cross product: the first product is held and compared with the second.
// ----------------------------------------------------------------------------
module cpve_cross (
  input  logic           clk_i,
  input  cpve_pkg::win_t win_i,
  input  logic           sel_i,   // 0: e0x*e1y, 1: e0y*e1x
  input  logic           ld_i,    // hold first product
  output logic           gt_o     // cross product > 0
);
  import cpve_pkg::*;

  logic signed [16:0] e0x, e0y, e1x, e1y, op_a, op_b;
  logic signed [33:0] prod, p1_q;

  assign e0x  = 17'(win_i.v1.x) - 17'(win_i.v0.x);
  assign e0y  = 17'(win_i.v1.y) - 17'(win_i.v0.y);
  assign e1x  = 17'(win_i.v2.x) - 17'(win_i.v1.x);
  assign e1y  = 17'(win_i.v2.y) - 17'(win_i.v1.y);
  assign op_a = sel_i ? e0y : e0x;
  assign op_b = sel_i ? e1x : e1y;
  // 17x17 signed product, full 34-bit result
  assign prod = op_a * op_b;
  assign gt_o = p1_q > prod;

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      p1_q <= prod;
    end
  end

endmodule

FILE: rtl/convex_polygon_vertex_editor.sv
// ----------------------------------------------------------------------------
// convex_polygon_vertex_editor
// Polygon store with clear/append/insert/move/remove and a convexity walk.
// ----------------------------------------------------------------------------
// Clear and append: result registered on accept. Test and move: a walk over n
// vertices reads and loads the first two, then per edge pair reads, loads and forms
// both cross-product terms. Insert: up to count walks of count+1 vertices, then a
// read and a write per shifted entry and a final write. Remove: a read and a write
// per shifted entry, then a count update. Not ready until the result word is taken.
// Memory and multiplier set the cost. Reset clears the count, not the vertex memory.
module convex_polygon_vertex_editor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           mode_i,
  input  logic signed [15:0]   point_x_i,
  input  logic signed [15:0]   point_y_i,
  input  logic [5:0]           vertex_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 ok_o,
  output logic [6:0]           position_o,
  output logic [6:0]           vertex_count_o
);
  import cpve_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_LD   = 7'b0000100,
    S_M1   = 7'b0001000,
    S_M2   = 7'b0010000,
    S_SRD  = 7'b0100000,
    S_SWR  = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [2:0]      mode_q, mode_d;
  vtx_t            pt_q, pt_d;
  logic [CntW-1:0] idx_q, idx_d, cnt_q, cnt_d, n_q, n_d, k_q, k_d;
  logic [CntW-1:0] j_q, j_d, i_q, i_d, ci;
  logic            ptsel_q, ptsel_d, cls_q, cls_d;
  logic            ok_q, ok_d, ov_q, ov_d;
  logic [6:0]      pos_q, pos_d;
  win_t            win_q, win_d;

  vtx_t            mem [MaxVert];
  vtx_t            rdata_q, wdata, cand;
  logic            re, we, gt, xsel, xld;
  logic [AddrW-1:0] raddr, waddr;

  cpve_cross u_cross (
    .clk_i (clk_i),
    .win_i (win_q),
    .sel_i (xsel),
    .ld_i  (xld),
    .gt_o  (gt)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign ci   = (k_q >= n_q) ? k_q - n_q : k_q;
  assign cand = ptsel_q ? pt_q : rdata_q;

  always_comb begin
    state_d = state_q;  mode_d = mode_q;  pt_d = pt_q;   idx_d = idx_q;
    cnt_d   = cnt_q;    n_d    = n_q;     k_d  = k_q;    j_d   = j_q;
    i_d     = i_q;      ptsel_d = ptsel_q; cls_d = cls_q;
    ok_d    = ok_q;     pos_d  = pos_q;   ov_d = ov_q;   win_d = win_q;
    re = 1'b0; we = 1'b0; raddr = '0; waddr = '0; wdata = pt_q;
    xsel = 1'b0; xld = 1'b0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          mode_d = mode_i;
          pt_d   = '{x: point_x_i, y: point_y_i};
          idx_d  = CntW'(vertex_index_i);
          ok_d   = 1'b0;
          pos_d  = '0;
          k_d    = '0;
          wdata  = '{x: point_x_i, y: point_y_i};
          case (mode_i)
            MODE_CLEAR: begin
              cnt_d = '0; ok_d = 1'b1; ov_d = 1'b1;
            end
            MODE_APPEND: begin
              ov_d = 1'b1;
              if (cnt_q < CntW'(MaxVert)) begin
                we = 1'b1; waddr = cnt_q[AddrW-1:0];
                pos_d = 7'(cnt_q); cnt_d = cnt_q + 1'b1; ok_d = 1'b1;
              end
            end
            MODE_TEST: begin
              n_d = cnt_q;
              if (cnt_q < CntW'(3)) begin
                ok_d = 1'b1; ov_d = 1'b1;
              end else begin
                state_d = S_RD;
              end
            end
            MODE_INSERT: begin
              if (cnt_q >= CntW'(MaxVert)) begin
                ov_d = 1'b1;
              end else if (cnt_q < CntW'(2)) begin
                we = 1'b1; waddr = cnt_q[AddrW-1:0];
                pos_d = 7'(cnt_q); cnt_d = cnt_q + 1'b1; ok_d = 1'b1;
                ov_d = 1'b1;
              end else begin
                n_d = cnt_q + 1'b1; j_d = cnt_q; state_d = S_RD;
              end
            end
            MODE_MOVE: begin
              n_d = cnt_q;
              if (CntW'(vertex_index_i) >= cnt_q) begin
                ov_d = 1'b1;
              end else if (cnt_q < CntW'(3)) begin
                we = 1'b1; waddr = vertex_index_i; ok_d = 1'b1; ov_d = 1'b1;
              end else begin
                state_d = S_RD;
              end
            end
            MODE_REMOVE: begin
              if (CntW'(vertex_index_i) >= cnt_q) begin
                ov_d = 1'b1;
              end else begin
                i_d = CntW'(vertex_index_i); state_d = S_SRD;
              end
            end
            default: begin
              ov_d = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        // map candidate index onto the stored polygon
        ptsel_d = 1'b0;
        raddr   = ci[AddrW-1:0];
        if (mode_q == MODE_INSERT) begin
          if (ci == j_q) begin
            ptsel_d = 1'b1;
          end else if (ci > j_q) begin
            raddr = AddrW'(ci - 1'b1);
          end
        end else if (mode_q == MODE_MOVE && ci == idx_q) begin
          ptsel_d = 1'b1;
        end
        re = 1'b1;
        state_d = S_LD;
      end
      S_LD: begin
        win_d = '{v0: win_q.v1, v1: win_q.v2, v2: cand};
        if (k_q >= CntW'(2)) begin
          state_d = S_M1;
        end else begin
          k_d = k_q + 1'b1; state_d = S_RD;
        end
      end
      S_M1: begin
        xsel = 1'b0; xld = 1'b1; state_d = S_M2;
      end
      S_M2: begin
        xsel = 1'b1;
        if (k_q == CntW'(2)) begin
          cls_d = gt;
        end
        if (k_q != CntW'(2) && gt != cls_q) begin
          // sign class changed: not convex
          case (mode_q)
            MODE_INSERT: begin
              if (j_q == CntW'(1)) begin
                ov_d = 1'b1; state_d = S_IDLE;
              end else begin
                j_d = j_q - 1'b1; k_d = '0; state_d = S_RD;
              end
            end
            default: begin
              ov_d = 1'b1; state_d = S_IDLE;
            end
          endcase
        end else if (k_q == n_q + 1'b1) begin
          case (mode_q)
            MODE_INSERT: begin
              i_d = cnt_q; pos_d = 7'(j_q); state_d = S_SRD;
            end
            MODE_MOVE: begin
              we = 1'b1; waddr = idx_q[AddrW-1:0];
              ok_d = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
            end
            default: begin
              ok_d = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
            end
          endcase
        end else begin
          k_d = k_q + 1'b1; state_d = S_RD;
        end
      end
      S_SRD: begin
        if (mode_q == MODE_INSERT) begin
          if (i_q > j_q) begin
            re = 1'b1; raddr = AddrW'(i_q - 1'b1); state_d = S_SWR;
          end else begin
            we = 1'b1; waddr = j_q[AddrW-1:0];
            cnt_d = cnt_q + 1'b1; ok_d = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
          end
        end else begin
          if (i_q + 1'b1 < cnt_q) begin
            re = 1'b1; raddr = AddrW'(i_q + 1'b1); state_d = S_SWR;
          end else begin
            cnt_d = cnt_q - 1'b1; ok_d = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
          end
        end
      end
      S_SWR: begin
        we = 1'b1; waddr = i_q[AddrW-1:0]; wdata = rdata_q;
        i_d = (mode_q == MODE_INSERT) ? i_q - 1'b1 : i_q + 1'b1;
        state_d = S_SRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;  pt_q <= pt_d;   idx_q <= idx_d; n_q <= n_d;
    k_q    <= k_d;     j_q  <= j_d;    i_q   <= i_d;   ptsel_q <= ptsel_d;
    cls_q  <= cls_d;   ok_q <= ok_d;   pos_q <= pos_d; win_q <= win_d;
  end

  assign in_ready_o     = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o    = ov_q;
  assign ok_o           = ok_q;
  assign position_o     = pos_q;
  assign vertex_count_o = 7'(cnt_q);

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxVert)) else $error("vertex count above capacity");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE)) else $error("ready while busy");
  a_ld_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LD) |-> $past(state_q == S_RD)) else $error("load without read");
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWR) |-> $past(state_q == S_SRD)) else $error("shift write w/o read");

endmodule
